/* hw/rtl/wczs_pkg.sv */
// Package for the wire charge zero suppression block.
// Holds the request function codes and the fixed-point constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wczs_pkg;

    typedef enum logic [1:0] {
        FUNC_START = 2'd0,
        FUNC_HIT   = 2'd1,
        FUNC_READ  = 2'd2,
        FUNC_MASK  = 2'd3
    } func_t;

    localparam int          BIN_W    = 24;
    localparam int          CHARGE_W = 20;
    localparam int          THR_W    = 24;
    localparam int          WIRE_W   = 8;
    localparam int          AMP_W    = 30;
    localparam logic [5:0]  GAIN     = 6'd53;
    localparam logic [23:0] BIN_MAX  = 24'hFFFFFF;

endpackage

`default_nettype wire

/* hw/rtl/wczs_req_if.sv */
// Request channel of the wire charge zero suppression block.
// Depends on wczs_pkg for the function code type.
`timescale 1ns / 1ps
`default_nettype none

interface wczs_req_if;
    logic                valid;
    logic                ready;
    wczs_pkg::func_t     func;
    logic [7:0]          wire_req;
    logic [19:0]         charge;
    logic signed [23:0]  threshold;
    logic [31:0]         event_number;
    logic [31:0]         detector_id;
    logic                dead;

    modport source (
        output valid, func, wire_req, charge, threshold, event_number, detector_id, dead,
        input  ready
    );
    modport sink (
        input  valid, func, wire_req, charge, threshold, event_number, detector_id, dead,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/wczs_digi_if.sv */
// Digi output channel of the wire charge zero suppression block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface wczs_digi_if;
    logic        valid;
    logic        ready;
    logic [7:0]  wire_out;
    logic [31:0] event_out;
    logic [31:0] detector_out;
    logic [23:0] charge_out;

    modport source (
        output valid, wire_out, event_out, detector_out, charge_out,
        input  ready
    );
    modport sink (
        input  valid, wire_out, event_out, detector_out, charge_out,
        output ready
    );
endinterface

`default_nettype wire

/* hw/rtl/wczs_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
// A read of the address written in the same cycle returns the old data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wczs_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* hw/rtl/wczs_clear.sv */
// Clearing sequencer that zeroes every wire entry after reset.
// Sweeps one entry per cycle; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module wczs_clear #(
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    output logic                          busy,
    output logic [$clog2(DEPTH)-1:0]      addr
);

    localparam int AW = $clog2(DEPTH);

    logic          busy_reg;
    logic          busy_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        if (busy_reg)
        begin
            if (cnt_reg == AW'(DEPTH - 1))
            begin
                busy_next = 1'b0;
            end
            else
            begin
                cnt_next = cnt_reg + AW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign busy = busy_reg;
    assign addr = cnt_reg;

endmodule

`default_nettype wire

/* hw/rtl/wire_charge_zero_suppression.sv */
// Top level of the wire charge zero suppression block.
// Depends on wczs_pkg, wczs_req_if, wczs_digi_if, wczs_ram and wczs_clear.
//
// Usage: requests arrive on the req channel and carry a function code.
// A start request latches the event number, detector id and threshold.
// A hit request adds charge to one wire's bin, saturating at full scale.
// A readout request tests one wire, clears its bin and, when the charge
// times the gain of 53 exceeds the threshold, the wire is not dead and is
// not wire 0, sends one digi on the digi channel. A mask request sets or
// clears the wire's dead flag. Hit, readout and mask requests for wires at or past NUM_WIRES do nothing.
// Each wire's bin and dead flag share one RAM entry that is read in the
// cycle a request is taken and written back from the s1 stage, with the last
// write forwarded, so one request is taken per cycle unless a digi stalls.
// A readout request passes the s1 stage and the output register before its digi is valid.
// After reset the block sweeps the RAM to zero, one entry per cycle, and
// takes no request until the sweep is done.
// While a digi waits on a stalled receiver the block takes no request, and
// a request already taken holds in the pipeline until the digi is taken.
`timescale 1ns / 1ps
`default_nettype none

module wire_charge_zero_suppression #(
    parameter int NUM_WIRES = 256
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    wczs_req_if.sink    req,
    wczs_digi_if.source digi
);

    import wczs_pkg::*;

    localparam int AW = $clog2(NUM_WIRES);
    localparam int EW = BIN_W + 1;

    logic          clr_busy;
    logic [AW-1:0] clr_addr;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [EW-1:0] ram_wdata;
    logic [EW-1:0] ram_rdata;

    logic          en;
    logic          accept;

    logic                    s1_valid_reg;
    logic                    s1_valid_next;
    func_t                   s1_func_reg;
    logic [AW-1:0]           s1_addr_reg;
    logic                    s1_range_reg;
    logic [CHARGE_W-1:0]     s1_charge_reg;
    logic signed [THR_W-1:0] s1_thr_reg;
    logic [31:0]             s1_event_reg;
    logic [31:0]             s1_det_reg;
    logic                    s1_dead_reg;

    logic signed [THR_W-1:0] thr_reg;
    logic [31:0]             event_reg;
    logic [31:0]             det_reg;

    logic                    fwd_valid_reg;
    logic [AW-1:0]           fwd_addr_reg;
    logic [EW-1:0]           fwd_data_reg;

    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [WIRE_W-1:0]       out_wire_reg;
    logic [31:0]             out_event_reg;
    logic [31:0]             out_det_reg;
    logic [BIN_W-1:0]        out_charge_reg;

    logic [EW-1:0]           entry;
    logic [BIN_W-1:0]        bin;
    logic                    bin_dead;
    logic [BIN_W:0]          sum;
    logic [BIN_W-1:0]        sat;
    logic [AMP_W-1:0]        amp;
    logic                    fire;
    logic                    s1_we;
    logic [EW-1:0]           s1_wdata;

    wczs_clear #(
        .DEPTH (NUM_WIRES)
    ) u_clear (
        .clk   (clk),
        .rst_n (rst_n),
        .busy  (clr_busy),
        .addr  (clr_addr)
    );

    wczs_ram #(
        .WIDTH (EW),
        .DEPTH (NUM_WIRES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (accept),
        .raddr (AW'(req.wire_req)),
        .rdata (ram_rdata)
    );

    assign en        = !out_valid_reg || digi.ready;
    assign req.ready = en && !clr_busy;
    assign accept    = req.valid && req.ready;

    assign entry    = (fwd_valid_reg && fwd_addr_reg == s1_addr_reg) ? fwd_data_reg : ram_rdata;
    assign bin      = entry[BIN_W-1:0];
    assign bin_dead = entry[BIN_W];
    assign sum      = {1'b0, bin} + (BIN_W + 1)'(s1_charge_reg);
    assign sat      = sum[BIN_W] ? BIN_MAX : sum[BIN_W-1:0];
    assign amp      = AMP_W'(bin) * AMP_W'(GAIN);

    always_comb
    begin
        fire = s1_valid_reg && s1_range_reg && (s1_func_reg == FUNC_READ)
            && (s1_addr_reg != '0) && !bin_dead
            && ($signed({2'b00, amp}) > 32'(thr_reg));
        s1_we = en && s1_valid_reg && s1_range_reg && (s1_func_reg != FUNC_START);
        case (s1_func_reg)
            FUNC_HIT:  s1_wdata = {bin_dead, sat};
            FUNC_MASK: s1_wdata = {s1_dead_reg, bin};
            default:   s1_wdata = {bin_dead, {BIN_W{1'b0}}};
        endcase
    end

    assign ram_we    = clr_busy || s1_we;
    assign ram_waddr = clr_busy ? clr_addr : s1_addr_reg;
    assign ram_wdata = clr_busy ? '0 : s1_wdata;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (en)
        begin
            s1_valid_next = accept;
        end
        out_valid_next = out_valid_reg;
        if (en)
        begin
            out_valid_next = fire;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            thr_reg       <= '0;
            event_reg     <= '0;
            det_reg       <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (clr_busy)
            begin
                fwd_valid_reg <= 1'b0;
            end
            else if (s1_we)
            begin
                fwd_valid_reg <= 1'b1;
            end
            if (en && s1_valid_reg && s1_func_reg == FUNC_START)
            begin
                thr_reg   <= s1_thr_reg;
                event_reg <= s1_event_reg;
                det_reg   <= s1_det_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_func_reg   <= req.func;
            s1_addr_reg   <= AW'(req.wire_req);
            s1_range_reg  <= 32'(req.wire_req) < 32'(NUM_WIRES);
            s1_charge_reg <= req.charge;
            s1_thr_reg    <= req.threshold;
            s1_event_reg  <= req.event_number;
            s1_det_reg    <= req.detector_id;
            s1_dead_reg   <= req.dead;
        end
        if (s1_we)
        begin
            fwd_addr_reg <= s1_addr_reg;
            fwd_data_reg <= s1_wdata;
        end
        if (en && fire)
        begin
            out_wire_reg   <= WIRE_W'(s1_addr_reg);
            out_event_reg  <= event_reg;
            out_det_reg    <= det_reg;
            out_charge_reg <= bin;
        end
    end

    assign digi.valid        = out_valid_reg;
    assign digi.wire_out     = out_wire_reg;
    assign digi.event_out    = out_event_reg;
    assign digi.detector_out = out_det_reg;
    assign digi.charge_out   = out_charge_reg;

    a_no_req_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy |-> !req.ready
    ) else $error("request taken during clearing sweep");

    a_no_pipe_while_clearing : assert property (
        @(posedge clk) disable iff (!rst_n) clr_busy |-> !s1_valid_reg
    ) else $error("pipeline busy during clearing sweep");

    a_no_wire_zero : assert property (
        @(posedge clk) disable iff (!rst_n) digi.valid |-> digi.wire_out != '0
    ) else $error("digi reported for wire zero");

    a_readout_clears : assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_we && s1_func_reg == FUNC_READ) |-> ram_wdata[BIN_W-1:0] == '0
    ) else $error("readout did not clear the bin");

    a_digi_after_readout : assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(digi.valid) |-> $past(s1_valid_reg && s1_func_reg == FUNC_READ)
    ) else $error("digi without a readout request");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// Testbench for wire_charge_zero_suppression: directed and random requests with idle and
// stall phases, every digi checked against a predictor of the charge bins and dead flags.
// Depends on wczs_pkg, wczs_req_if, wczs_digi_if and the block's RTL.

module tb;
    import wczs_pkg::*;

    localparam int NUM_WIRES = 256;

    typedef struct {
        func_t              func;
        logic [7:0]         wire_idx;
        logic [19:0]        charge;
        logic signed [23:0] thr;
        logic [31:0]        evt_num;
        logic [31:0]        det_id;
        logic               dead;
    } request_t;

    typedef struct {
        logic [7:0]  wire_idx;
        logic [31:0] evt_num;
        logic [31:0] det_id;
        logic [23:0] charge;
    } digi_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    wczs_req_if  req_ch ();
    wczs_digi_if digi_ch ();

    wire_charge_zero_suppression #(
        .NUM_WIRES (NUM_WIRES)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .digi  (digi_ch)
    );

    logic [23:0]        model_bins [NUM_WIRES];
    logic               model_dead [NUM_WIRES];
    logic signed [23:0] model_thr;
    logic [31:0]        model_evt;
    logic [31:0]        model_det;
    digi_t              pending_digis [$];
    digi_t              exp_digi;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    int mismatch_count = 0;
    int sent_count     = 0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial
    begin
        #2_500_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic void predict_request(request_t r);
        logic [24:0] sum;
        longint      amp;
        digi_t       d;
        if (r.func == FUNC_START)
        begin
            model_thr = r.thr;
            model_evt = r.evt_num;
            model_det = r.det_id;
            return;
        end
        if (r.wire_idx >= NUM_WIRES)
            return;
        case (r.func)
            FUNC_HIT:
            begin
                sum = {1'b0, model_bins[r.wire_idx]} + 25'(r.charge);
                model_bins[r.wire_idx] = (sum > {1'b0, BIN_MAX}) ? BIN_MAX : sum[23:0];
            end
            FUNC_MASK:
                model_dead[r.wire_idx] = r.dead;
            FUNC_READ:
            begin
                amp = longint'(model_bins[r.wire_idx]) * longint'(GAIN);
                if (r.wire_idx != 8'd0 && amp > longint'(model_thr) && !model_dead[r.wire_idx])
                begin
                    d.wire_idx = r.wire_idx;
                    d.evt_num  = model_evt;
                    d.det_id   = model_det;
                    d.charge   = model_bins[r.wire_idx];
                    pending_digis.push_back(d);
                end
                model_bins[r.wire_idx] = '0;
            end
            default: ;
        endcase
    endfunction

    function automatic request_t rand_request(func_t f);
        request_t r;
        r.func     = f;
        r.wire_idx = 8'($urandom);
        r.charge   = 20'($urandom);
        r.thr      = 24'($urandom);
        r.evt_num  = $urandom;
        r.det_id   = $urandom;
        r.dead     = 1'($urandom);
        return r;
    endfunction

    // Called at a rising edge; returns at the rising edge where the request is taken.
    task automatic send_request(request_t r);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.func         <= r.func;
        req_ch.wire_req     <= r.wire_idx;
        req_ch.charge       <= r.charge;
        req_ch.threshold    <= r.thr;
        req_ch.event_number <= r.evt_num;
        req_ch.detector_id  <= r.det_id;
        req_ch.dead         <= r.dead;
        do
            @(negedge clk);
        while (req_ch.ready !== 1'b1);
        @(posedge clk);
        predict_request(r);
        sent_count++;
    endtask

    task automatic issue_request(func_t f, logic [7:0] w, logic [19:0] q, logic [23:0] thr,
                                 logic [31:0] ev, logic [31:0] det, logic dead);
        request_t r;
        r.func     = f;
        r.wire_idx = w;
        r.charge   = q;
        r.thr      = thr;
        r.evt_num  = ev;
        r.det_id   = det;
        r.dead     = dead;
        send_request(r);
    endtask

    task automatic wait_drained();
        int waited;
        req_ch.valid <= 1'b0;
        waited = 0;
        while (pending_digis.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
    endtask

    task automatic test_directed_cases();
        issue_request(FUNC_START, 8'd0, 20'd0, 24'h7FFFFF, 32'hFFFF_FFFF, 32'h0, 1'b0);
        issue_request(FUNC_HIT, 8'd1, 20'hFFFFF, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_HIT, 8'd1, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_READ, 8'd1, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_READ, 8'd1, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_START, 8'hFF, 20'hFFFFF, 24'h800000, 32'h0, 32'hFFFF_FFFF, 1'b1);
        issue_request(FUNC_READ, 8'd2, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_HIT, 8'd0, 20'hFFFFF, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_READ, 8'd0, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_MASK, 8'd3, 20'h0, 24'h0, 32'h0, 32'h0, 1'b1);
        issue_request(FUNC_HIT, 8'd3, 20'd100, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_READ, 8'd3, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_MASK, 8'd3, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_HIT, 8'd3, 20'd100, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_READ, 8'd3, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_HIT, 8'd255, 20'h10, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_START, 8'd0, 20'h0, 24'd848, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0);
        issue_request(FUNC_READ, 8'd255, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_HIT, 8'd254, 20'h10, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_START, 8'd0, 20'h0, 24'd847, 32'h1234_5678, 32'h8765_4321, 1'b0);
        issue_request(FUNC_READ, 8'd254, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
    endtask

    task automatic test_saturation();
        issue_request(FUNC_START, 8'd0, 20'h0, 24'h7FFFFF, 32'h0000_0001, 32'h0000_0002, 1'b0);
        repeat (17) issue_request(FUNC_HIT, 8'd128, 20'hFFFFF, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_READ, 8'd128, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_HIT, 8'd128, 20'hFFFFF, 24'h0, 32'h0, 32'h0, 1'b0);
        issue_request(FUNC_READ, 8'd128, 20'h0, 24'h0, 32'h0, 32'h0, 1'b0);
    endtask

    // Mostly whole events: a start, hits on a few wires, maybe a mask, then their readouts.
    task automatic test_random_traffic(int n_items);
        request_t   r;
        logic [7:0] wires [$];
        int         target;
        longint     amp;
        target = sent_count + n_items;
        while (sent_count < target)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                r = rand_request(FUNC_START);
                case ($urandom_range(0, 3))
                    0: r.thr = 24'($urandom);
                    1: r.thr = 24'($urandom_range(0, 4000));
                    2: r.thr = 24'(0 - int'($urandom_range(0, 4000)));
                    default: r.thr = 24'($urandom & 32'h7F_FFFF);
                endcase
                send_request(r);
                wires.delete();
                repeat ($urandom_range(1, 6))
                    wires.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 3))
                                                                : 8'($urandom));
                foreach (wires[i])
                begin
                    repeat ($urandom_range(1, 4))
                    begin
                        r = rand_request(FUNC_HIT);
                        r.wire_idx = wires[i];
                        r.charge = 20'($urandom) >> $urandom_range(0, 19);
                        send_request(r);
                    end
                end
                if ($urandom_range(0, 99) < 20)
                begin
                    r = rand_request(FUNC_MASK);
                    r.wire_idx = wires[$urandom_range(0, wires.size() - 1)];
                    send_request(r);
                end
                if ($urandom_range(0, 99) < 10)
                begin
                    repeat (17)
                    begin
                        r = rand_request(FUNC_HIT);
                        r.wire_idx = wires[0];
                        r.charge = 20'hFFFFF - 20'($urandom_range(0, 3));
                        send_request(r);
                    end
                end
                if ($urandom_range(0, 99) < 30)
                begin
                    r = rand_request(FUNC_START);
                    amp = longint'(model_bins[wires[0]]) * longint'(GAIN)
                          + longint'(int'($urandom_range(0, 2)) - 1);
                    if (amp >= 0 && amp <= 64'sh7F_FFFF)
                        r.thr = 24'(amp);
                    send_request(r);
                end
                wires.shuffle();
                foreach (wires[i])
                begin
                    r = rand_request(FUNC_READ);
                    r.wire_idx = wires[i];
                    send_request(r);
                end
            end
            else
            begin
                repeat ($urandom_range(1, 4))
                    send_request(rand_request(func_t'($urandom_range(0, 3))));
            end
        end
    endtask

    // The receiver holds off for a long stretch while requests keep coming.
    task automatic test_input_backpressure();
        request_t r;
        r = rand_request(FUNC_START);
        r.thr = 24'h800000;
        send_request(r);
        hold_left = 400;
        for (int i = 1; i <= 40; i++)
        begin
            r = rand_request(FUNC_MASK);
            r.wire_idx = 8'(i);
            r.dead = 1'b0;
            send_request(r);
            r = rand_request(FUNC_HIT);
            r.wire_idx = 8'(i);
            send_request(r);
            r = rand_request(FUNC_READ);
            r.wire_idx = 8'(i);
            send_request(r);
        end
    endtask

    initial
    begin
        digi_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                digi_ch.ready <= 1'b0;
            end
            else
                digi_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && digi_ch.valid === 1'b1 && digi_ch.ready === 1'b1)
        begin
            if (pending_digis.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected digi: wire %0d event %h detector %h charge %h",
                             digi_ch.wire_out, digi_ch.event_out, digi_ch.detector_out,
                             digi_ch.charge_out);
                mismatch_count++;
            end
            else
            begin
                exp_digi = pending_digis.pop_front();
                if (digi_ch.wire_out !== exp_digi.wire_idx
                    || digi_ch.event_out !== exp_digi.evt_num
                    || digi_ch.detector_out !== exp_digi.det_id
                    || digi_ch.charge_out !== exp_digi.charge)
                begin
                    if (mismatch_count < 10)
                        $display("digi mismatch: expected wire %0d event %h detector %h %s %h",
                                 exp_digi.wire_idx, exp_digi.evt_num, exp_digi.det_id,
                                 "charge", exp_digi.charge);
                    if (mismatch_count < 10)
                        $display("               got      wire %0d event %h detector %h %s %h",
                                 digi_ch.wire_out, digi_ch.event_out, digi_ch.detector_out,
                                 "charge", digi_ch.charge_out);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.func         = FUNC_START;
        req_ch.wire_req     = '0;
        req_ch.charge       = '0;
        req_ch.threshold    = '0;
        req_ch.event_number = '0;
        req_ch.detector_id  = '0;
        req_ch.dead         = 1'b0;
        foreach (model_bins[i])
        begin
            model_bins[i] = '0;
            model_dead[i] = 1'b0;
        end
        model_thr = '0;
        model_evt = '0;
        model_det = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_cases();
        test_saturation();
        wait_drained();

        test_random_traffic(410);
        wait_drained();
        send_idle_pct  = 76;
        recv_stall_pct = 0;
        test_random_traffic(410);
        wait_drained();
        send_idle_pct  = 0;
        recv_stall_pct = 76;
        test_random_traffic(410);
        wait_drained();
        send_idle_pct  = 32;
        recv_stall_pct = 32;
        test_random_traffic(410);
        wait_drained();

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_input_backpressure();
        wait_drained();

        mismatch_count += pending_digis.size();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/wczs_pkg.sv
hw/rtl/wczs_req_if.sv
hw/rtl/wczs_digi_if.sv
hw/rtl/wczs_ram.sv
hw/rtl/wczs_clear.sv
hw/rtl/wire_charge_zero_suppression.sv
test/tb.sv
